[design/kfr_pkg.sv]
// ----------------------------------------------------------------------------
// kfr_pkg: keyframe reduction shared types and constants
// Request and result payload structs, register indexes, fixed-point widths.
// ----------------------------------------------------------------------------
package kfr_pkg;

   localparam int unsigned TimeWidth  = 32;
   localparam int unsigned CompWidth  = 32;
   localparam int unsigned TolWidth   = 31;
   localparam int unsigned FracWidth  = 16;
   localparam int unsigned IndexWidth = 1;

   localparam logic [IndexWidth-1:0] RegEnableReduction = 1'd0;
   localparam logic [IndexWidth-1:0] RegMaxError        = 1'd1;

   typedef struct packed {
      logic [TimeWidth-1:0]        key_time;
      logic signed [CompWidth-1:0] key_x;
      logic signed [CompWidth-1:0] key_y;
      logic signed [CompWidth-1:0] key_z;
      logic                        track_end;
   } req_type;

   typedef struct packed {
      logic [TimeWidth-1:0]        kept_time;
      logic signed [CompWidth-1:0] kept_x;
      logic signed [CompWidth-1:0] kept_y;
      logic signed [CompWidth-1:0] kept_z;
      logic                        final_of_track;
   } rsp_type;

endpackage

[design/keyframe_reduction_vs_kept_core.sv]
// ----------------------------------------------------------------------------
// keyframe_reduction_vs_kept_core: keyframe reduction by interpolation error
// Drops middle keyframes of a 3D track that a linear interpolation between
// the last kept keyframe and the successor reproduces within tolerance.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one keyframe per request (valid/stall). track_end marks the
//            last keyframe of a track.
//   rsp_*  : kept keyframes (valid/stall), zero, one or two per request,
//            in track order; final_of_track marks the track's last one.
//   csr_*  : register writes (valid/ready), index 0 enable_reduction,
//            index 1 max_error. Accepted only while idle.
// Timing:
//   A middle keyframe is tested when its successor arrives. A small sequencer
//   runs the test serially: restoring division for t, then per component a
//   17-step shift-add multiply, an error step, a 33-step squaring and an
//   accumulate step; division is skipped when t is 0 or 1. req_stall stays
//   high until the request is finished, so a new request is taken only when
//   the sequencer is idle. A stalled result holds in the output register
//   and extends req_stall until it is taken.
// Reset clears the track state (no keyframe seen), sets enable_reduction
// to 1 and max_error to 0.
// ----------------------------------------------------------------------------
module keyframe_reduction_vs_kept_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  kfr_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output kfr_pkg::rsp_type   rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [kfr_pkg::IndexWidth-1:0] csr_index,
   input  logic [31:0]        csr_data
);
   import kfr_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECIDE, ST_DIV, ST_MUL, ST_ERR, ST_SQ, ST_CMP,
      ST_EMIT1, ST_EMIT2, ST_WAIT2
   } state_type;

   state_type          state_ff;
   logic               enable_ff;
   logic [TolWidth-1:0] max_error_ff;
   logic [1:0]         phase_ff;
   logic [TimeWidth-1:0] anchor_time_ff, pending_time_ff;
   logic signed [CompWidth-1:0] anchor_vec_ff [3];
   logic signed [CompWidth-1:0] pending_vec_ff [3];
   req_type            cur_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;
   logic               keep_ff;

   // shared datapath registers
   logic [32:0]        rem_ff;      // divide remainder
   logic [32:0]        divisor_ff;
   logic [16:0]        t_ff;        // quotient / multiplier, Q1.16
   logic [5:0]         count_ff;
   logic [1:0]         comp_ff;
   logic signed [49:0] prod_ff;     // t * diff
   logic [32:0]        mag_ff;      // |error|, up to 33 bits
   logic [65:0]        sq_ff;
   logic [66:0]        sum_ff;

   logic signed [32:0] diff_w, err_w;
   logic signed [33:0] interp_w;
   logic [33:0]        sub_w;
   logic [66:0]        sum_w;
   logic [63:0]        tol2_w;
   logic [TimeWidth-1:0] nt_w, pt_w, at_w;
   logic               rsp_free_w, rsp_load_w;

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign nt_w = cur_ff.key_time;
   assign pt_w = pending_time_ff;
   assign at_w = anchor_time_ff;

   assign rsp_free_w = !rsp_valid_ff || !rsp_stall;
   assign rsp_load_w = rsp_free_w &&
      ((state_ff == ST_EMIT1 && keep_ff) ||
       (state_ff == ST_EMIT2 && (cur_ff.track_end || phase_ff == 2'd0)));

   function automatic logic signed [CompWidth-1:0] comp_of(input req_type r,
                                                            input logic [1:0] i);
      logic signed [CompWidth-1:0] v;
      case (i)
         2'd0:    v = r.key_x;
         2'd1:    v = r.key_y;
         default: v = r.key_z;
      endcase
      return v;
   endfunction

   assign diff_w = 33'(comp_of(cur_ff, comp_ff)) - 33'(anchor_vec_ff[comp_ff]);
   // floor shift of a signed product is an arithmetic shift
   assign interp_w = 34'(anchor_vec_ff[comp_ff]) + 34'(prod_ff >>> FracWidth);
   assign err_w = 33'(35'(pending_vec_ff[comp_ff]) - 35'(interp_w));
   assign sub_w = {rem_ff, 1'b0} - {1'b0, divisor_ff};
   assign sum_w = sum_ff + {1'b0, sq_ff};
   assign tol2_w = 64'(max_error_ff) * 64'(max_error_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         enable_ff    <= 1'b1;
         max_error_ff <= '0;
         phase_ff     <= 2'd0;
         rsp_valid_ff <= 1'b0;
         anchor_time_ff  <= '0;
         pending_time_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            anchor_vec_ff[i]  <= '0;
            pending_vec_ff[i] <= '0;
         end
      end else begin
         if (rsp_load_w) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (csr_valid) begin
                  if (csr_index == RegEnableReduction) enable_ff <= csr_data[0];
                  else if (csr_index == RegMaxError) max_error_ff <= csr_data[TolWidth-1:0];
               end
               if (req_valid) begin
                  cur_ff   <= req_data;
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               keep_ff <= !enable_ff;
               if (phase_ff == 2'd2) begin
                  if (!enable_ff) begin
                     state_ff <= ST_EMIT1;
                  end else begin
                     sum_ff <= '0;
                     comp_ff <= 2'd0;
                     if (nt_w <= at_w || pt_w <= at_w) begin
                        t_ff <= '0;
                        count_ff <= '0;
                        prod_ff <= '0;
                        state_ff <= ST_MUL;
                     end else if (pt_w >= nt_w) begin
                        t_ff <= 17'h10000;
                        count_ff <= '0;
                        prod_ff <= '0;
                        state_ff <= ST_MUL;
                     end else begin
                        rem_ff     <= {1'b0, pt_w - at_w};
                        divisor_ff <= {1'b0, nt_w - at_w};
                        t_ff       <= '0;
                        count_ff   <= 6'd15;
                        state_ff   <= ST_DIV;
                     end
                  end
               end else begin
                  state_ff <= ST_EMIT2;
               end
            end
            ST_DIV: begin
               // one restoring step; remainder < divisor so quotient < 2^16
               if (!sub_w[33]) begin
                  rem_ff <= sub_w[32:0];
                  t_ff   <= {t_ff[15:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[31:0], 1'b0};
                  t_ff   <= {t_ff[15:0], 1'b0};
               end
               if (count_ff == '0) begin
                  count_ff <= '0;
                  prod_ff  <= '0;
                  state_ff <= ST_MUL;
               end else count_ff <= count_ff - 6'd1;
            end
            ST_MUL: begin
               // shift-add over the 17 bits of t, one bit a cycle
               if (t_ff[count_ff[4:0]])
                  prod_ff <= prod_ff + (50'(diff_w) <<< count_ff[4:0]);
               if (count_ff == 6'd16) state_ff <= ST_ERR;
               else count_ff <= count_ff + 6'd1;
            end
            ST_ERR: begin
               mag_ff   <= err_w[32] ? 33'(-err_w) : 33'(err_w);
               sq_ff    <= '0;
               count_ff <= '0;
               state_ff <= ST_SQ;
            end
            ST_SQ: begin
               if (mag_ff[count_ff])
                  sq_ff <= sq_ff + (66'(mag_ff) << count_ff);
               if (count_ff == 6'd32) begin
                  state_ff <= ST_CMP;
               end else count_ff <= count_ff + 6'd1;
            end
            ST_CMP: begin
               sum_ff <= sum_w;
               if (comp_ff == 2'd2) begin
                  keep_ff  <= (sum_w > 67'(tol2_w));
                  state_ff <= ST_EMIT1;
               end else begin
                  comp_ff  <= comp_ff + 2'd1;
                  count_ff <= '0;
                  prod_ff  <= '0;
                  state_ff <= ST_MUL;
               end
            end
            ST_EMIT1: begin
               if (!keep_ff) state_ff <= ST_EMIT2;
               else if (rsp_free_w) begin
                  rsp_ff <= '{pending_time_ff, pending_vec_ff[0], pending_vec_ff[1],
                              pending_vec_ff[2], 1'b0};
                  anchor_time_ff <= pending_time_ff;
                  for (int i = 0; i < 3; i++) anchor_vec_ff[i] <= pending_vec_ff[i];
                  state_ff <= ST_EMIT2;
               end
            end
            ST_EMIT2: begin
               if (cur_ff.track_end || phase_ff == 2'd0) begin
                  if (rsp_free_w) begin
                     rsp_ff <= '{cur_ff.key_time, cur_ff.key_x, cur_ff.key_y,
                                 cur_ff.key_z, cur_ff.track_end};
                     if (cur_ff.track_end) phase_ff <= 2'd0;
                     else begin
                        anchor_time_ff <= cur_ff.key_time;
                        anchor_vec_ff[0] <= cur_ff.key_x;
                        anchor_vec_ff[1] <= cur_ff.key_y;
                        anchor_vec_ff[2] <= cur_ff.key_z;
                        phase_ff <= 2'd1;
                     end
                     state_ff <= ST_WAIT2;
                  end
               end else begin
                  pending_time_ff   <= cur_ff.key_time;
                  pending_vec_ff[0] <= cur_ff.key_x;
                  pending_vec_ff[1] <= cur_ff.key_y;
                  pending_vec_ff[2] <= cur_ff.key_z;
                  phase_ff <= 2'd2;
                  state_ff <= ST_WAIT2;
               end
            end
            ST_WAIT2: begin
               if (rsp_free_w) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_busy_no_cfg: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !csr_ready) else $error("cfg ready while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");
   a_phase: assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'd3) else $error("bad phase");
   a_div_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (t_ff <= 17'h10000)) else $error("t out of range");
`endif

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: keyframe reduction core
// Streams 3D keyframe tracks through the core under random request gaps and
// result stalls, predicts the kept keyframes from an internal model of the
// interpolation-error test and compares each result field by field.
// ----------------------------------------------------------------------------
module testbench;
   import kfr_pkg::*;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [IndexWidth-1:0] csr_index;
   logic [31:0] csr_data;

   keyframe_reduction_vs_kept_core dut (.*);

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   req_type pending_keys[$];
   rsp_type kept_expected[$];
   int unsigned failures = 0;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   bit drive_en = 1'b0;

   // model state
   bit          mdl_enable;
   logic [30:0] mdl_tolerance;
   logic [31:0] anchor_time, held_time;
   longint      anchor_vec[3], held_vec[3];
   int          fill_phase;

   function automatic void append_key(req_type k);
      pending_keys = {pending_keys, k};
   endfunction

   function automatic void append_kept(rsp_type r);
      kept_expected = {kept_expected, r};
   endfunction

   function automatic int unsigned random_gap();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      return $urandom_range(0, 3);
   endfunction

   function automatic longint floor_shift16(longint v);
      return v >>> 16;
   endfunction

   function automatic bit held_key_is_kept(logic [31:0] nt, longint nv[3]);
      longint unsigned frac, tol_sq, total, sq, mag;
      longint interp, err;
      if (nt <= anchor_time) frac = 0;
      else if (held_time <= anchor_time) frac = 0;
      else if (held_time >= nt) frac = 65536;
      else frac = ({32'd0, held_time - anchor_time} << 16) / {32'd0, nt - anchor_time};
      tol_sq = longint'(mdl_tolerance) * longint'(mdl_tolerance);
      total = 0;
      for (int c = 0; c < 3; c++) begin
         interp = anchor_vec[c] + floor_shift16(longint'(frac) * (nv[c] - anchor_vec[c]));
         err = held_vec[c] - interp;
         mag = err < 0 ? longint'(-err) : longint'(err);
         sq = mag * mag;
         if (total > 64'hFFFF_FFFF_FFFF_FFFF - sq) total = 64'hFFFF_FFFF_FFFF_FFFF;
         else total = total + sq;
      end
      return total > tol_sq;
   endfunction

   function automatic rsp_type make_kept(logic [31:0] t, longint v[3], bit fin);
      rsp_type r;
      r.kept_time = t;
      r.kept_x = v[0][31:0];
      r.kept_y = v[1][31:0];
      r.kept_z = v[2][31:0];
      r.final_of_track = fin;
      return r;
   endfunction

   function automatic void predict_kept(req_type k);
      longint kv[3];
      kv[0] = longint'(k.key_x);
      kv[1] = longint'(k.key_y);
      kv[2] = longint'(k.key_z);
      if (fill_phase == 2) begin
         if (!mdl_enable || held_key_is_kept(k.key_time, kv)) begin
            append_kept(make_kept(held_time, held_vec, 1'b0));
            anchor_time = held_time;
            anchor_vec = held_vec;
         end
      end
      if (k.track_end) begin
         append_kept(make_kept(k.key_time, kv, 1'b1));
         fill_phase = 0;
      end else if (fill_phase == 0) begin
         append_kept(make_kept(k.key_time, kv, 1'b0));
         anchor_time = k.key_time;
         anchor_vec = kv;
         fill_phase = 1;
      end else begin
         held_time = k.key_time;
         held_vec = kv;
         fill_phase = 2;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
         fill_phase = 0;
         anchor_time = '0;
         held_time = '0;
         anchor_vec = '{0, 0, 0};
         held_vec = '{0, 0, 0};
      end else if (req_valid && !req_stall) begin
         predict_kept(req_data);
         void'(pending_keys.pop_front());
         req_valid <= 1'b0;
         gap_left <= random_gap();
      end else if (!req_valid && drive_en && pending_keys.size() > 0) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
         end else begin
            req_data <= pending_keys[0];
            req_valid <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (kept_expected.size() == 0) begin
               $error("unexpected result time=%h", rsp_data.kept_time);
               failures++;
            end else begin
               rsp_type e;
               e = kept_expected.pop_front();
               if (e.kept_time !== rsp_data.kept_time) begin
                  $error("kept_time exp %h got %h", e.kept_time, rsp_data.kept_time);
                  failures++;
               end
               if (e.kept_x !== rsp_data.kept_x) begin
                  $error("kept_x exp %h got %h", e.kept_x, rsp_data.kept_x);
                  failures++;
               end
               if (e.kept_y !== rsp_data.kept_y) begin
                  $error("kept_y exp %h got %h", e.kept_y, rsp_data.kept_y);
                  failures++;
               end
               if (e.kept_z !== rsp_data.kept_z) begin
                  $error("kept_z exp %h got %h", e.kept_z, rsp_data.kept_z);
                  failures++;
               end
               if (e.final_of_track !== rsp_data.final_of_track) begin
                  $error("final_of_track exp %b got %b", e.final_of_track,
                         rsp_data.final_of_track);
                  failures++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 4) == 0) stall_left <= random_gap();
         end
      end
   end

   function automatic req_type make_key(logic [31:0] t, logic [31:0] x, logic [31:0] y,
                                        logic [31:0] z, bit last);
      req_type k;
      k.key_time = t;
      k.key_x = x;
      k.key_y = y;
      k.key_z = z;
      k.track_end = last;
      return k;
   endfunction

   task automatic wait_drained();
      while (pending_keys.size() > 0 || req_valid || kept_expected.size() > 0)
         @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_reg(logic [IndexWidth-1:0] idx, logic [31:0] value);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == RegEnableReduction) mdl_enable = value[0];
      else mdl_tolerance = value[30:0];
      @(posedge clock);
   endtask

   task automatic queue_track(int unsigned len, bit smooth);
      logic [31:0] t, step;
      logic [31:0] v[3], d[3];
      t = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 32'h0010_0000);
      step = $urandom_range(1, 32'h0004_0000);
      for (int c = 0; c < 3; c++) begin
         v[c] = smooth ? $urandom_range(0, 32'h0100_0000) - 32'h0080_0000 : $urandom();
         d[c] = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
      end
      for (int unsigned i = 0; i < len; i++) begin
         append_key(make_key(t, v[0], v[1], v[2], i == len - 1));
         if (smooth) begin
            t = t + step;
            for (int c = 0; c < 3; c++)
               v[c] = v[c] + d[c] + $urandom_range(0, 64) - 32;
            if ($urandom_range(0, 7) == 0) v[$urandom_range(0, 2)] = $urandom();
            if ($urandom_range(0, 15) == 0) t = $urandom();
         end else begin
            t = $urandom_range(0, 1) ? $urandom() : t + $urandom_range(0, 100);
            for (int c = 0; c < 3; c++) v[c] = $urandom();
         end
      end
   endtask

   initial begin
      int unsigned sent;
      csr_valid = 1'b0;
      csr_index = RegEnableReduction;
      csr_data = '0;
      mdl_enable = 1'b1;
      mdl_tolerance = '0;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: lone keyframe, pair, extremes, collinear, degenerate times
      append_key(make_key(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1));
      append_key(make_key(0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0));
      append_key(make_key(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1, 1));
      append_key(make_key(32'h0001_0000, 0, 0, 0, 0));
      append_key(make_key(32'h0002_0000, 32'h0001_0000, 0, 0, 0));
      append_key(make_key(32'h0003_0000, 32'h0002_0000, 0, 0, 0));
      append_key(make_key(32'h0003_0000, 32'h0005_0000, 0, 0, 0));
      append_key(make_key(32'h0001_0000, 32'h0001_0000, 1, 1, 0));
      append_key(make_key(32'h0000_8000, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 0));
      append_key(make_key(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 0));
      append_key(make_key(32'h0000_0010, 0, 0, 0, 1));
      drive_en = 1'b1;
      wait_drained();

      write_reg(RegMaxError, 32'h0000_8000);
      append_key(make_key(0, 0, 0, 0, 0));
      append_key(make_key(32'h0001_0000, 32'h0000_8000, 0, 0, 0));
      append_key(make_key(32'h0002_0000, 32'h0000_8000, 0, 0, 0));
      append_key(make_key(32'h0003_0000, 32'h0001_8000, 0, 0, 1));
      wait_drained();

      write_reg(RegEnableReduction, 32'hFFFF_FFFE);
      queue_track(6, 1'b1);
      wait_drained();
      write_reg(RegEnableReduction, 32'h0000_0001);
      write_reg(RegMaxError, 32'hFFFF_FFFF);
      queue_track(6, 1'b1);
      wait_drained();

      sent = 0;
      while (sent < 400) begin
         int unsigned len;
         len = $urandom_range(0, 9) == 0 ? 1 : $urandom_range(2, 12);
         if ($urandom_range(0, 9) == 0) begin
            wait_drained();
            case ($urandom_range(0, 3))
               0: write_reg(RegEnableReduction, $urandom());
               1: write_reg(RegMaxError, 32'h0);
               2: write_reg(RegMaxError, 32'h7FFF_FFFF);
               default: write_reg(RegMaxError, $urandom_range(0, 32'h0004_0000));
            endcase
         end
         queue_track(len, $urandom_range(0, 4) != 0);
         sent += len;
         while (pending_keys.size() > 8) @(posedge clock);
      end
      wait_drained();

      if (failures == 0) $display("testbench: PASS");
      else $display("testbench: FAIL");
      $finish;
   end

   initial begin
      #20ms;
      $display("testbench: FAIL");
      $finish;
   end

endmodule
